### design/dbsf_pkg.sv
// ---------------------------------------------------------------------------
// dbsf_pkg
// Shared constants and types for the dilated box subsample filter.
// ---------------------------------------------------------------------------
package dbsf_pkg;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_STEP  = 4;
  localparam int MAX_HEIGHT    = 1024;
  localparam int CNT_W         = 21;

  // Register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;
  localparam logic [1:0] REG_CHAN4  = 2'd3;

  // Input commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_t;

  // Accumulated neighborhood handed to the divider.
  typedef struct packed {
    logic [11:0] sum0;
    logic [11:0] sum1;
    logic [11:0] sum2;
    logic [11:0] sum3;
    logic [3:0]  count;
  } acc_t;

endpackage

### design/dilated_box_subsample_filter.sv
// ---------------------------------------------------------------------------
// dilated_box_subsample_filter
// Dilated 3x3 box filter over a raster stream of packed pixels.
// ---------------------------------------------------------------------------
// Each accepted transaction is handled on its own: a pixel is written to the
// ring store, then, if the pending output pixel has all its neighbors, the
// nine neighbors are read through the single memory read port and summed,
// and the sums go through a twelve-step serial divider. A transaction that
// yields a result holds the input from the accepting cycle through the nine
// reads, the registered memory read and the settling of the sums, the divider,
// and the presenting of the result, which lasts while the receiver stalls. A
// transaction that yields no result leaves the input ready. Output runs
// step*width+step pixels behind input; drain ticks flush the tail. Any register
// write restarts the frame. The ring store needs no clearing after reset.
module dilated_box_subsample_filter #(
  parameter int MAX_WIDTH = dbsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_STEP  = dbsf_pkg::DEF_MAX_STEP
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [31:0] pixel_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pixel_out,
  output logic        frame_end
);

  localparam int DEPTH  = 2 * (MAX_STEP * MAX_WIDTH + MAX_STEP) + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = dbsf_pkg::CNT_W;
  localparam int WW     = $clog2(MAX_WIDTH + 1);

  // Configuration registers.
  logic [10:0] image_width, image_height;
  logic [2:0]  sample_step;
  logic        four_channels;

  // Frame counters.
  logic [CW-1:0] pixels_received, pixels_emitted;

  // Effective settings.
  logic [10:0] w_eff, h_eff;
  logic [4:0]  s_eff;
  logic [CW-1:0] n_pix, lag, need;

  always_comb begin
    w_eff = (image_width == 11'd0) ? 11'd1 :
            ({21'd0, image_width} > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : image_width;
    h_eff = (image_height == 11'd0) ? 11'd1 :
            ({21'd0, image_height} > 32'(dbsf_pkg::MAX_HEIGHT)) ?
            11'(dbsf_pkg::MAX_HEIGHT) : image_height;
    s_eff = ({29'd0, sample_step} > 32'(MAX_STEP)) ? 5'(MAX_STEP) : {2'd0, sample_step};
  end

  // Frame size and lag follow the registers directly.
  always_comb begin
    n_pix = CW'(w_eff) * CW'(h_eff);
    lag   = CW'(s_eff) * CW'(w_eff) + CW'(s_eff);
  end

  logic [WW-1:0] w_narrow;
  assign w_narrow = WW'(w_eff);

  // Control.
  dbsf_pkg::state_t state, state_next;
  logic [3:0]  tap;
  logic        rd_pend;
  logic        div_start, div_done;
  logic [31:0] div_q;
  dbsf_pkg::acc_t acc;
  logic        last;
  logic signed [CW+1:0] q_addr;
  logic        q_ok, q_ok_d;
  logic        tap_ok;

  // Memory wiring.
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [31:0]       rd_data;
  logic [CW-1:0]     ring_wr;
  logic [ADDR_W-1:0] ring_base;

  assign in_ready = (state == dbsf_pkg::ST_IDLE) && !cfg_we;
  assign wr_en = in_valid && in_ready && (cmd == dbsf_pkg::CMD_PIXEL) &&
                 (pixels_received < n_pix);

  // Write slot follows the received count modulo the ring depth.
  logic [ADDR_W-1:0] wr_slot;
  always_ff @(posedge clk) begin
    if (rst || cfg_we || (last && out_valid && out_ready)) begin
      wr_slot <= '0;
    end else if (wr_en) begin
      wr_slot <= (32'(wr_slot) == DEPTH - 1) ? '0 : wr_slot + 1'b1;
    end
  end
  assign wr_addr = wr_slot;
  assign ring_wr = pixels_received;

  // Slot of the pending output pixel.
  logic [ADDR_W-1:0] em_slot;
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      em_slot <= '0;
    end else if (out_valid && out_ready) begin
      em_slot <= (last || 32'(em_slot) == DEPTH - 1) ? '0 : em_slot + 1'b1;
    end
  end
  assign ring_base = em_slot;

  // Neighbor offset for the current tap: dy from tap/3, dx from tap%3.
  logic signed [1:0] dy, dx;
  logic signed [CW+1:0] offs;
  logic signed [ADDR_W+1:0] slot_s;
  always_comb begin
    unique case (tap)
      4'd0, 4'd1, 4'd2: dy = -2'sd1;
      4'd3, 4'd4, 4'd5: dy = 2'sd0;
      default:          dy = 2'sd1;
    endcase
    unique case (tap)
      4'd0, 4'd3, 4'd6: dx = -2'sd1;
      4'd1, 4'd4, 4'd7: dx = 2'sd0;
      default:          dx = 2'sd1;
    endcase
    offs = (CW+2)'(dy * $signed({1'b0, lag - CW'(s_eff)})) +
           (CW+2)'(dx * $signed({1'b0, s_eff}));
    q_addr = $signed({2'b0, pixels_emitted}) + offs;
    q_ok   = (q_addr >= 0) && (q_addr < $signed({2'b0, n_pix}));
    slot_s = $signed({2'b0, ring_base}) + (ADDR_W+2)'(offs);
    if (slot_s < 0) begin
      slot_s = slot_s + (ADDR_W+2)'(DEPTH);
    end else if (slot_s >= (ADDR_W+2)'(DEPTH)) begin
      slot_s = slot_s - (ADDR_W+2)'(DEPTH);
    end
    rd_addr = slot_s[ADDR_W-1:0];
  end
  assign tap_ok = w_narrow != '0;

  // Readiness of the pending pixel after this transaction.
  logic [CW-1:0] rx_after;
  always_comb begin
    rx_after = pixels_received + {{(CW-1){1'b0}}, wr_en};
    need = pixels_emitted + lag + 1'b1;
    if (need > n_pix) need = n_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A pixel beyond the frame is dropped and never triggers a result.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      dbsf_pkg::ST_IDLE: begin
        if (in_valid && in_ready && ((cmd == dbsf_pkg::CMD_DRAIN) || wr_en) &&
            (pixels_emitted < n_pix) && (rx_after >= need)) begin
          state_next = dbsf_pkg::ST_READ;
        end
      end
      dbsf_pkg::ST_READ: begin
        if (tap == 4'd9 && !rd_pend) begin
          state_next = dbsf_pkg::ST_DIV;
          div_start  = 1'b1;
        end
      end
      dbsf_pkg::ST_DIV: begin
        if (div_done) state_next = dbsf_pkg::ST_OUT;
      end
      dbsf_pkg::ST_OUT: begin
        if (out_ready) state_next = dbsf_pkg::ST_IDLE;
      end
      default: state_next = dbsf_pkg::ST_IDLE;
    endcase
  end

  // Tap sequencing and accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap     <= '0;
      rd_pend <= 1'b0;
    end else if (state == dbsf_pkg::ST_IDLE) begin
      tap     <= '0;
      rd_pend <= 1'b0;
    end else if (state == dbsf_pkg::ST_READ) begin
      rd_pend <= (tap != 4'd9) && tap_ok;
      if (tap != 4'd9) tap <= tap + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_ok_d <= q_ok;
    if (state == dbsf_pkg::ST_IDLE) begin
      acc <= '0;
    end else if (state == dbsf_pkg::ST_READ && rd_pend && q_ok_d) begin
      acc.sum0  <= acc.sum0 + {4'd0, rd_data[7:0]};
      acc.sum1  <= acc.sum1 + {4'd0, rd_data[15:8]};
      acc.sum2  <= acc.sum2 + {4'd0, rd_data[23:16]};
      acc.sum3  <= acc.sum3 + {4'd0, rd_data[31:24]};
      acc.count <= acc.count + 4'd1;
    end
  end

  dbsf_window_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (pixel_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dbsf_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .acc   (acc),
    .done  (div_done),
    .quot  (div_q)
  );

  // Result register.
  assign out_valid = (state == dbsf_pkg::ST_OUT);
  assign last      = (pixels_emitted + 1'b1 == n_pix);
  always_ff @(posedge clk) begin
    if (div_done) begin
      pixel_out <= four_channels ? div_q : {8'd0, div_q[23:0]};
      frame_end <= last;
    end
  end

  // Counters and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 11'd1;
      image_height    <= 11'd1;
      sample_step     <= 3'd0;
      four_channels   <= 1'b1;
      pixels_received <= '0;
      pixels_emitted  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dbsf_pkg::REG_WIDTH:  image_width   <= cfg_data;
        dbsf_pkg::REG_HEIGHT: image_height  <= cfg_data;
        dbsf_pkg::REG_STEP:   sample_step   <= cfg_data[2:0];
        dbsf_pkg::REG_CHAN4:  four_channels <= cfg_data[0];
        default: ;
      endcase
      pixels_received <= '0;
      pixels_emitted  <= '0;
    end else begin
      if (wr_en) pixels_received <= ring_wr + 1'b1;
      if (out_valid && out_ready) begin
        if (last) begin
          pixels_received <= '0;
          pixels_emitted  <= '0;
        end else begin
          pixels_emitted <= pixels_emitted + 1'b1;
        end
      end
    end
  end

endmodule

### design/dbsf_window_mem.sv
// ---------------------------------------------------------------------------
// dbsf_window_mem
// Ring store of recent pixels, one write port and one registered read port.
// ---------------------------------------------------------------------------
module dbsf_window_mem #(
  parameter int DEPTH  = 8201,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [31:0]       wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [31:0]       rd_data
);

  logic [31:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### design/dbsf_divider.sv
// ---------------------------------------------------------------------------
// dbsf_divider
// Restoring divider of four 12-bit channel sums by a count of 1 to 9.
// ---------------------------------------------------------------------------
module dbsf_divider (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dbsf_pkg::acc_t   acc,
  output logic             done,
  output logic [31:0]      quot
);

  logic [11:0] rem  [4];
  logic [11:0] num  [4];
  logic [3:0]  dvs;
  logic [3:0]  bit_cnt;
  logic        busy;

  // One quotient bit per channel per cycle while busy.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= 4'd11;
      end else if (busy) begin
        if (bit_cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        bit_cnt <= bit_cnt - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num[0] <= acc.sum0;
      num[1] <= acc.sum1;
      num[2] <= acc.sum2;
      num[3] <= acc.sum3;
      for (int c = 0; c < 4; c++) begin
        rem[c] <= '0;
      end
      dvs <= (acc.count == 4'd0) ? 4'd1 : acc.count;
    end else if (busy) begin
      for (int c = 0; c < 4; c++) begin
        logic [12:0] trial;
        trial = {rem[c], num[c][11]};
        if (trial >= {9'd0, dvs}) begin
          rem[c] <= 12'(trial - {9'd0, dvs});
          num[c] <= {num[c][10:0], 1'b1};
        end else begin
          rem[c] <= trial[11:0];
          num[c] <= {num[c][10:0], 1'b0};
        end
      end
    end
  end

  // Quotients are at most 255, so the low byte suffices.
  assign quot = {num[3][7:0], num[2][7:0], num[1][7:0], num[0][7:0]};

endmodule
